>>> hdl/vrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_pkg
// Shared types and constants of the voxel ray collision check unit.
// ----------------------------------------------------------------------------
package vrc_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int INV_W     = 32;
    localparam int CFG_IDX_W = 2;

    // occupancy map: 2^18 bits held as 64-bit rows
    localparam int MAP_AW = 18;
    localparam int ROW_BW = 6;
    localparam int ROW_W  = 1 << ROW_BW;
    localparam int ROW_AW = MAP_AW - ROW_BW;
    localparam int ROWS   = 1 << ROW_AW;

    // shared multiplier and crossing-time differences
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIFF_W = 130;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z = 2'd2;

    // map write request
    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
        logic [ROW_W-1:0]  data;
    } ram_wr_t;

endpackage

>>> hdl/vrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_req_if / vrc_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface vrc_req_if;
    import vrc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [MAP_AW-1:0]         cell_address;
    logic                      cell_blocked;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;

    modport source (
        output valid, op, cell_address, cell_blocked,
        output start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, op, cell_address, cell_blocked,
        input  start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

interface vrc_rsp_if;
    logic valid;
    logic ready;
    logic path_free;
    logic off_map;

    modport source (output valid, path_free, off_map, input ready);
    modport sink (input valid, path_free, off_map, output ready);
endinterface

>>> hdl/vrc_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_map_ram
// Occupancy map row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vrc_map_ram (
    input  logic                       clk,
    input  vrc_pkg::ram_wr_t           wr,
    input  logic [vrc_pkg::ROW_AW-1:0] rd_row,
    output logic [vrc_pkg::ROW_W-1:0]  rd_data
);
    import vrc_pkg::*;

    logic [ROW_W-1:0] mem [ROWS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row] <= wr.data;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_row];
    end

endmodule

>>> hdl/vrc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_mul
// Shared 33x33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vrc_mul (
    input  logic                               clk,
    input  logic signed [vrc_pkg::MUL_W-1:0]   a,
    input  logic signed [vrc_pkg::MUL_W-1:0]   b,
    output logic signed [vrc_pkg::PROD_W-1:0]  p_reg
);
    import vrc_pkg::*;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

>>> hdl/voxel_ray_collision_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_collision_check_unit
// Occupancy map plus a 3D DDA walk that checks a segment against the map.
// ----------------------------------------------------------------------------
// Write word: accept, then row read, then row write-back. Check word: scaling,
// axis setup and 24 partial products on the shared multiplier after acceptance;
// per voxel walked an address step and a map check (the address step only if
// off the map); then the post, which waits while an earlier result is not taken.
// One word at a time; the next word is taken while a result waits.
// After reset the map is cleared one row a cycle, all 4096 rows; no word taken.
// ----------------------------------------------------------------------------
module voxel_ray_collision_check_unit #(
    parameter int DIM_X     = 64,
    parameter int DIM_Y     = 64,
    parameter int DIM_Z     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vrc_pkg::INV_W-1:0]     cfg_data,
    vrc_req_if.sink                       req,
    vrc_rsp_if.source                     rsp
);
    import vrc_pkg::*;

    localparam int SH       = 2 * FRAC_BITS;
    localparam int IW       = 65 - SH;
    localparam int XW       = $clog2(DIM_X);
    localparam int YW       = $clog2(DIM_Y);
    localparam int ZW       = $clog2(DIM_Z);
    localparam int CW       = $clog2(DIM_X * DIM_Y * DIM_Z) + 1;
    localparam int SCALE_N  = 6;
    localparam int CROSS_N  = 24;
    localparam logic [INV_W-1:0] INV_RESET = 32'd65536;
    localparam logic signed [IW-1:0] DIMX_S = IW'(DIM_X);
    localparam logic signed [IW-1:0] DIMY_S = IW'(DIM_Y);
    localparam logic signed [IW-1:0] DIMZ_S = IW'(DIM_Z);
    localparam logic [63:0] ONE = 64'd1 << SH;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCALE, ST_AXIS, ST_CROSS,
        ST_WADDR, ST_WCHK, ST_RESULT, ST_WR_RD, ST_WR_WB
    } state_t;

    state_t            state_reg;
    logic [4:0]        cnt_reg;
    logic [ROW_AW-1:0] clr_reg;
    logic              mv_reg;
    logic [2:0]        mt_reg;
    logic [1:0]        msh_reg;
    logic              ov_reg;
    logic              pf_reg;
    logic              om_reg;
    logic [INV_W-1:0]  inv_reg [3];

    // datapath registers
    logic [MAP_AW-1:0]         wa_reg;
    logic                      wb_reg;
    logic signed [COORD_W-1:0] pos_reg [6];
    logic signed [63:0]        se_reg [6];
    logic signed [IW-1:0]      idx_reg [3];
    logic signed [IW-1:0]      end_reg [3];
    logic                      neg_reg [3];
    logic                      act_reg [3];
    logic [63:0]               den_reg [3];
    logic [63:0]               num_reg [3];
    logic signed [DIFF_W-1:0]  dxy_reg, dxz_reg, dyz_reg;
    logic [ROW_BW-1:0]         bit_reg;
    logic                      res_pf_reg, res_om_reg;

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    ram_wr_t                  ram_wr;
    logic [ROW_AW-1:0]        ram_rd_row;
    logic [ROW_W-1:0]         ram_rd_data;

    vrc_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    vrc_map_ram u_map (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_row  (ram_rd_row),
        .rd_data (ram_rd_data)
    );

    // multiplier operand select
    logic [2:0]  sk;
    logic [2:0]  ct;
    logic [1:0]  cp;
    logic [1:0]  na, db;
    logic [63:0] a_full, b_full;
    logic [INV_W-1:0] inv_sel;

    always_comb
    begin
        sk = cnt_reg[2:0];
        ct = cnt_reg[4:2];
        cp = cnt_reg[1:0];
        unique case (sk)
            3'd0, 3'd3: inv_sel = inv_reg[0];
            3'd1, 3'd4: inv_sel = inv_reg[1];
            default:    inv_sel = inv_reg[2];
        endcase
        unique case (ct)
            3'd0:    begin na = 2'd0; db = 2'd1; end
            3'd1:    begin na = 2'd1; db = 2'd0; end
            3'd2:    begin na = 2'd0; db = 2'd2; end
            3'd3:    begin na = 2'd2; db = 2'd0; end
            3'd4:    begin na = 2'd1; db = 2'd2; end
            default: begin na = 2'd2; db = 2'd1; end
        endcase
        a_full = num_reg[na];
        b_full = den_reg[db];
        if (state_reg == ST_SCALE)
        begin
            mul_a = {pos_reg[(sk < 3'd6) ? sk : 3'd0][COORD_W-1],
                     pos_reg[(sk < 3'd6) ? sk : 3'd0]};
            mul_b = $signed({1'b0, inv_sel});
        end
        else
        begin
            mul_a = $signed({1'b0, cp[0] ? a_full[63:32] : a_full[31:0]});
            mul_b = $signed({1'b0, cp[1] ? b_full[63:32] : b_full[31:0]});
        end
    end

    // voxel bounds and map address
    logic off_now;
    logic [CW-1:0] lin_addr;
    logic [MAP_AW-1:0] map_addr;

    always_comb
    begin
        off_now = idx_reg[0][IW-1] || (idx_reg[0] >= DIMX_S)
               || idx_reg[1][IW-1] || (idx_reg[1] >= DIMY_S)
               || idx_reg[2][IW-1] || (idx_reg[2] >= DIMZ_S);
        lin_addr = CW'(idx_reg[0][XW-1:0]) * CW'(DIM_Y * DIM_Z)
                 + CW'(idx_reg[1][YW-1:0]) * CW'(DIM_Z)
                 + CW'(idx_reg[2][ZW-1:0]);
        map_addr = MAP_AW'(lin_addr);
    end

    // axis choice: ties go to z, or to y when x is not earlier
    logic tx_y, tx_z, ty_z;
    logic [1:0] adv;
    logic all_idle;

    always_comb
    begin
        tx_y = act_reg[0] && (!act_reg[1] || dxy_reg[DIFF_W-1]);
        tx_z = act_reg[0] && (!act_reg[2] || dxz_reg[DIFF_W-1]);
        ty_z = act_reg[1] && (!act_reg[2] || dyz_reg[DIFF_W-1]);
        if (tx_y)
        begin
            adv = tx_z ? 2'd0 : 2'd2;
        end
        else
        begin
            adv = ty_z ? 2'd1 : 2'd2;
        end
        all_idle = !act_reg[0] && !act_reg[1] && !act_reg[2];
    end

    // map port control
    always_comb
    begin
        ram_wr.en   = 1'b0;
        ram_wr.row  = clr_reg;
        ram_wr.data = '0;
        ram_rd_row  = map_addr[MAP_AW-1:ROW_BW];
        if (state_reg == ST_CLEAR)
        begin
            ram_wr.en = 1'b1;
        end
        else if (state_reg == ST_WR_WB)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.row  = wa_reg[MAP_AW-1:ROW_BW];
            ram_wr.data = ram_rd_data;
            ram_wr.data[wa_reg[ROW_BW-1:0]] = wb_reg;
        end
        if (state_reg == ST_WR_RD)
        begin
            ram_rd_row = wa_reg[MAP_AW-1:ROW_BW];
        end
    end

    logic in_fire;
    assign req.ready     = (state_reg == ST_IDLE);
    assign in_fire       = req.valid && (state_reg == ST_IDLE);
    assign rsp.valid     = ov_reg;
    assign rsp.path_free = pf_reg;
    assign rsp.off_map   = om_reg;

    // control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            mv_reg     <= 1'b0;
            mt_reg     <= '0;
            msh_reg    <= '0;
            ov_reg     <= 1'b0;
            pf_reg     <= 1'b0;
            om_reg     <= 1'b0;
            inv_reg[0] <= INV_RESET;
            inv_reg[1] <= INV_RESET;
            inv_reg[2] <= INV_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INV_X: inv_reg[0] <= cfg_data;
                    CFG_INV_Y: inv_reg[1] <= cfg_data;
                    CFG_INV_Z: inv_reg[2] <= cfg_data;
                    default:   ;
                endcase
            end
            // result valid: set on post, cleared when taken
            if (state_reg == ST_RESULT && (!ov_reg || rsp.ready))
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
            // product valid in the cycle after each issue
            mv_reg <= ((state_reg == ST_SCALE) && (cnt_reg < 5'(SCALE_N)))
                   || ((state_reg == ST_CROSS) && (cnt_reg < 5'(CROSS_N)));
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_fire)
                    begin
                        state_reg <= (req.op == OP_CHECK) ? ST_SCALE : ST_WR_RD;
                    end
                end
                ST_SCALE:
                begin
                    if (cnt_reg < 5'(SCALE_N))
                    begin
                        mt_reg  <= cnt_reg[2:0];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_AXIS;
                    end
                end
                ST_AXIS:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_CROSS;
                end
                ST_CROSS:
                begin
                    if (cnt_reg < 5'(CROSS_N))
                    begin
                        mt_reg  <= cnt_reg[4:2];
                        msh_reg <= 2'(cnt_reg[0]) + 2'(cnt_reg[1]);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_WADDR;
                    end
                end
                ST_WADDR:
                begin
                    state_reg <= off_now ? ST_RESULT : ST_WCHK;
                end
                ST_WCHK:
                begin
                    if (ram_rd_data[bit_reg] || all_idle)
                    begin
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        state_reg <= ST_WADDR;
                    end
                end
                ST_RESULT:
                begin
                    if (!ov_reg || rsp.ready)
                    begin
                        pf_reg    <= res_pf_reg;
                        om_reg    <= res_om_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WR_RD:
                begin
                    state_reg <= ST_WR_WB;
                end
                ST_WR_WB:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    logic [DIFF_W-1:0] pp;
    logic signed [IW-1:0] idx_step;

    always_comb
    begin
        pp = DIFF_W'(mul_p[63:0]) << (32 * msh_reg);
        idx_step = neg_reg[adv] ? idx_reg[adv] - IW'(1) : idx_reg[adv] + IW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wa_reg     <= req.cell_address;
            wb_reg     <= req.cell_blocked;
            pos_reg[0] <= req.start_x;
            pos_reg[1] <= req.start_y;
            pos_reg[2] <= req.start_z;
            pos_reg[3] <= req.end_x;
            pos_reg[4] <= req.end_y;
            pos_reg[5] <= req.end_z;
        end

        // scaled coordinates
        if (state_reg == ST_SCALE && mv_reg)
        begin
            se_reg[mt_reg] <= mul_p[63:0];
        end

        // per-axis walk setup
        if (state_reg == ST_AXIS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                idx_reg[i] <= IW'(se_reg[i] >>> SH);
                end_reg[i] <= IW'(se_reg[i+3] >>> SH);
                act_reg[i] <= IW'(se_reg[i] >>> SH) != IW'(se_reg[i+3] >>> SH);
                if (se_reg[i+3] > se_reg[i])
                begin
                    neg_reg[i] <= 1'b0;
                    den_reg[i] <= se_reg[i+3] - se_reg[i];
                    num_reg[i] <= ONE - (se_reg[i] & (ONE - 64'd1));
                end
                else if (se_reg[i+3] < se_reg[i])
                begin
                    neg_reg[i] <= 1'b1;
                    den_reg[i] <= se_reg[i] - se_reg[i+3];
                    num_reg[i] <= se_reg[i] & (ONE - 64'd1);
                end
                else
                begin
                    neg_reg[i] <= 1'b0;
                    den_reg[i] <= '0;
                    num_reg[i] <= '0;
                end
            end
            dxy_reg <= '0;
            dxz_reg <= '0;
            dyz_reg <= '0;
        end

        // crossing-time differences: even terms add, odd terms subtract
        if (state_reg == ST_CROSS && mv_reg)
        begin
            unique case (mt_reg[2:1])
                2'd0:
                    dxy_reg <= mt_reg[0] ? dxy_reg - $signed(pp) : dxy_reg + $signed(pp);
                2'd1:
                    dxz_reg <= mt_reg[0] ? dxz_reg - $signed(pp) : dxz_reg + $signed(pp);
                default:
                    dyz_reg <= mt_reg[0] ? dyz_reg - $signed(pp) : dyz_reg + $signed(pp);
            endcase
        end

        // voxel test
        if (state_reg == ST_WADDR)
        begin
            bit_reg    <= map_addr[ROW_BW-1:0];
            res_pf_reg <= 1'b0;
            res_om_reg <= 1'b1;
        end

        // step one axis; its crossing time grows by one cell
        if (state_reg == ST_WCHK)
        begin
            res_om_reg <= 1'b0;
            res_pf_reg <= !ram_rd_data[bit_reg];
            if (!ram_rd_data[bit_reg] && !all_idle)
            begin
                idx_reg[adv] <= idx_step;
                act_reg[adv] <= idx_step != end_reg[adv];
                unique case (adv)
                    2'd0:
                    begin
                        dxy_reg <= dxy_reg + $signed(DIFF_W'(den_reg[1]) << SH);
                        dxz_reg <= dxz_reg + $signed(DIFF_W'(den_reg[2]) << SH);
                    end
                    2'd1:
                    begin
                        dxy_reg <= dxy_reg - $signed(DIFF_W'(den_reg[0]) << SH);
                        dyz_reg <= dyz_reg + $signed(DIFF_W'(den_reg[2]) << SH);
                    end
                    default:
                    begin
                        dxz_reg <= dxz_reg - $signed(DIFF_W'(den_reg[0]) << SH);
                        dyz_reg <= dyz_reg - $signed(DIFF_W'(den_reg[1]) << SH);
                    end
                endcase
            end
        end
    end

endmodule
